@@ design/dpfc_pkg.sv @@
// Package for the depth plane false-color block: register map, codes and stage types.
package dpfc_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes, paddr[3:2]
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_COLOR_MODE   = 2'd2;

   // reset values
   localparam logic [10:0] FRAME_WIDTH_RST  = 11'd320;
   localparam logic [10:0] FRAME_HEIGHT_RST = 11'd240;
   localparam logic        COLOR_MODE_RST   = 1'b1;

   // plane codes
   localparam logic [1:0] PLANE_PHASE     = 2'd0;
   localparam logic [1:0] PLANE_AMPLITUDE = 2'd1;
   localparam logic [1:0] PLANE_AMBIENT   = 2'd2;
   localparam logic [1:0] PLANE_FLAGS     = 2'd3;

   // jet colormap segments, phase index bits [7:6]
   localparam logic [1:0] JET_SEG_GREEN_UP  = 2'd0;
   localparam logic [1:0] JET_SEG_BLUE_DOWN = 2'd1;
   localparam logic [1:0] JET_SEG_RED_UP    = 2'd2;
   localparam logic [1:0] JET_SEG_GREEN_DN  = 2'd3;

   localparam logic [7:0] PIX_FULL      = 8'd255;
   localparam logic [7:0] PIX_ZERO      = 8'd0;
   localparam logic [7:0] PIX_HALF      = 8'd128;
   localparam logic [7:0] JET_BLUE_TOP  = 8'd254;
   localparam logic [7:0] JET_RED_BASE  = 8'd2;
   localparam logic [7:0] JET_GREEN_TOP = 8'd252;

   // stage A: captured sample, mosaic place and frame check
   typedef struct packed {
      logic [1:0]  plane;
      logic [15:0] sample_value;
      logic [10:0] mosaic_x;
      logic [10:0] mosaic_y;
      logic        out_of_frame;
   } stage_a_type;

   // stage B: jet segment and ramp, or gray level
   typedef struct packed {
      logic        jet;
      logic [1:0]  seg;
      logic [7:0]  ramp;
      logic [7:0]  gray;
      logic [10:0] mosaic_x;
      logic [10:0] mosaic_y;
      logic        out_of_frame;
   } stage_b_type;

   // stage C: finished pixel
   typedef struct packed {
      logic        jet;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [10:0] mosaic_x;
      logic [10:0] mosaic_y;
      logic        out_of_frame;
   } stage_c_type;

endpackage

@@ design/depth_plane_false_color.sv @@
// Top level: false-color conversion of depth-camera plane samples into a 2x2 mosaic.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   req_    | in        | req_valid/req_ready | plane, row, column, sample_value
//   rsp_    | out       | rsp_valid/rsp_ready | red, green, blue, mosaic_x, mosaic_y,
//           |           |                     | out_of_frame
//   csr_    | in/out    | APB psel/penable    | frame_width, frame_height, color_mode
//
// Three register stages (A: mosaic add and frame compare, B: jet segment or gray level,
// C: final pixel, which is also the output register). rsp_valid rises once an accepted
// item has moved through stages A, B and C, and the result can then be taken; one item per
// cycle is taken while rsp_ready stays high.
// A stage takes a new item when it is empty or its content moves on in the same cycle,
// so a stall at rsp_ready backs up stage by stage without dropping or repeating an item.
// Synchronous reset empties all stages and loads the register reset values.
module depth_plane_false_color (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_plane,
   input  logic [9:0]                       req_row,
   input  logic [9:0]                       req_column,
   input  logic [15:0]                      req_sample_value,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_red,
   output logic [7:0]                       rsp_green,
   output logic [7:0]                       rsp_blue,
   output logic [10:0]                      rsp_mosaic_x,
   output logic [10:0]                      rsp_mosaic_y,
   output logic                             rsp_out_of_frame,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dpfc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dpfc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dpfc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import dpfc_pkg::*;

   logic [10:0] frame_width_ff,  frame_width_in;
   logic [10:0] frame_height_ff, frame_height_in;
   logic        color_mode_ff,   color_mode_in;

   logic        a_valid_ff, a_valid_in;
   logic        b_valid_ff, b_valid_in;
   logic        c_valid_ff, c_valid_in;
   stage_a_type a_data_ff,  a_data_in;
   stage_b_type b_data_ff,  b_data_in;
   stage_c_type c_data_ff,  c_data_in;

   logic        a_ready, b_ready, c_ready;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   // ---------------- configuration registers ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      color_mode_in   = color_mode_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_FRAME_WIDTH:  frame_width_in  = csr_pwdata[10:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_pwdata[10:0];
            REG_COLOR_MODE:   color_mode_in   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         REG_FRAME_WIDTH:  csr_prdata = {{(CSR_DATA_W-11){1'b0}}, frame_width_ff};
         REG_FRAME_HEIGHT: csr_prdata = {{(CSR_DATA_W-11){1'b0}}, frame_height_ff};
         REG_COLOR_MODE:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, color_mode_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline flow control ----------------
   assign c_ready   = ~c_valid_ff | rsp_ready;
   assign b_ready   = ~b_valid_ff | c_ready;
   assign a_ready   = ~a_valid_ff | b_ready;
   assign req_ready = a_ready;

   assign a_valid_in = a_ready ? req_valid  : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   // ---------------- stage A: mosaic place, frame check ----------------
   always_comb begin
      a_data_in              = a_data_ff;
      if (a_ready && req_valid) begin
         a_data_in.plane        = req_plane;
         a_data_in.sample_value = req_sample_value;
         // right half for amplitude and flags, lower half for ambient and flags
         a_data_in.mosaic_x     = req_plane[0] ? ({1'b0, req_column} + frame_width_ff)
                                               : {1'b0, req_column};
         a_data_in.mosaic_y     = req_plane[1] ? ({1'b0, req_row} + frame_height_ff)
                                               : {1'b0, req_row};
         a_data_in.out_of_frame = ({1'b0, req_column} >= frame_width_ff) ||
                                  ({1'b0, req_row} >= frame_height_ff);
      end
   end

   // ---------------- stage B: jet segment or gray level ----------------
   always_comb begin
      b_data_in = b_data_ff;
      if (b_ready && a_valid_ff) begin
         b_data_in.jet          = (a_data_ff.plane == PLANE_PHASE) && color_mode_ff;
         // phase index bits [11:4]: top two pick the segment, low six times four
         b_data_in.seg          = a_data_ff.sample_value[11:10];
         b_data_in.ramp         = {a_data_ff.sample_value[9:4], 2'b00};
         b_data_in.mosaic_x     = a_data_ff.mosaic_x;
         b_data_in.mosaic_y     = a_data_ff.mosaic_y;
         b_data_in.out_of_frame = a_data_ff.out_of_frame;
         case (a_data_ff.plane)
            PLANE_PHASE:     b_data_in.gray = a_data_ff.sample_value[13:6];
            PLANE_AMPLITUDE: begin
               // saturate in color mode, wrap in gray mode
               if (color_mode_ff && (a_data_ff.sample_value[15:10] != 6'd0))
                  b_data_in.gray = PIX_FULL;
               else
                  b_data_in.gray = a_data_ff.sample_value[9:2];
            end
            PLANE_AMBIENT:   b_data_in.gray = {a_data_ff.sample_value[4:0], 3'b000};
            default:         b_data_in.gray = a_data_ff.sample_value[3] ? PIX_HALF
                                                                        : PIX_ZERO;
         endcase
      end
   end

   // ---------------- stage C: final pixel ----------------
   always_comb begin
      c_data_in = c_data_ff;
      if (c_ready && b_valid_ff) begin
         c_data_in.jet          = b_data_ff.jet;
         c_data_in.mosaic_x     = b_data_ff.mosaic_x;
         c_data_in.mosaic_y     = b_data_ff.mosaic_y;
         c_data_in.out_of_frame = b_data_ff.out_of_frame;
         c_data_in.red          = b_data_ff.gray;
         c_data_in.green        = b_data_ff.gray;
         c_data_in.blue         = b_data_ff.gray;
         if (b_data_ff.jet) begin
            case (b_data_ff.seg)
               JET_SEG_GREEN_UP: begin
                  c_data_in.red   = PIX_ZERO;
                  c_data_in.green = b_data_ff.ramp;
                  c_data_in.blue  = PIX_FULL;
               end
               JET_SEG_BLUE_DOWN: begin
                  c_data_in.red   = PIX_ZERO;
                  c_data_in.green = PIX_FULL;
                  c_data_in.blue  = JET_BLUE_TOP - b_data_ff.ramp;
               end
               JET_SEG_RED_UP: begin
                  c_data_in.red   = b_data_ff.ramp + JET_RED_BASE;
                  c_data_in.green = PIX_FULL;
                  c_data_in.blue  = PIX_ZERO;
               end
               default: begin
                  c_data_in.red   = PIX_FULL;
                  c_data_in.green = JET_GREEN_TOP - b_data_ff.ramp;
                  c_data_in.blue  = PIX_ZERO;
               end
            endcase
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         color_mode_ff   <= COLOR_MODE_RST;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         color_mode_ff   <= color_mode_in;
         a_valid_ff      <= a_valid_in;
         b_valid_ff      <= b_valid_in;
         c_valid_ff      <= c_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      a_data_ff <= a_data_in;
      b_data_ff <= b_data_in;
      c_data_ff <= c_data_in;
   end

   // ---------------- outputs ----------------
   assign rsp_valid        = c_valid_ff;
   assign rsp_red          = c_data_ff.red;
   assign rsp_green        = c_data_ff.green;
   assign rsp_blue         = c_data_ff.blue;
   assign rsp_mosaic_x     = c_data_ff.mosaic_x;
   assign rsp_mosaic_y     = c_data_ff.mosaic_y;
   assign rsp_out_of_frame = c_data_ff.out_of_frame;

   // ---------------- assertions ----------------
   // an accepted item always lands in stage A
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> a_valid_ff)
      else $error("accepted item did not enter stage A");

   // every jet pixel has one channel at full scale
   jet_full_channel: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && c_data_ff.jet) |->
         (c_data_ff.red == PIX_FULL || c_data_ff.green == PIX_FULL ||
          c_data_ff.blue == PIX_FULL))
      else $error("jet pixel without a full-scale channel");

   // non-jet pixels are gray
   gray_equal: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !c_data_ff.jet) |->
         (c_data_ff.red == c_data_ff.green && c_data_ff.green == c_data_ff.blue))
      else $error("gray pixel with unequal channels");

   // an in-frame item has a mosaic place inside the full mosaic
   in_frame_place: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !c_data_ff.out_of_frame) |->
         ({1'b0, c_data_ff.mosaic_x} < {frame_width_ff, 1'b0} &&
          {1'b0, c_data_ff.mosaic_y} < {frame_height_ff, 1'b0}))
      else $error("in-frame item placed outside the mosaic");

endmodule
